### rtl/core/ccrc_pkg.sv
`timescale 1ns / 1ps

package ccrc_pkg;

   localparam int unsigned CRC_W       = 32;
   localparam int unsigned BYTE_W      = 8;
   localparam int unsigned CSR_INDEX_W = 3;

   localparam logic [CRC_W-1:0] RESET_POLYNOMIAL = 32'h04C1_1DB7;
   localparam logic [CRC_W-1:0] RESET_INITIAL    = 32'hFFFF_FFFF;

   typedef enum logic [CSR_INDEX_W-1:0] {
      CSR_POLYNOMIAL     = 3'd0,
      CSR_INITIAL_VALUE  = 3'd1,
      CSR_REFLECT_INPUT  = 3'd2,
      CSR_REFLECT_OUTPUT = 3'd3,
      CSR_INVERT_OUTPUT  = 3'd4
   } csr_index_type;

   // Eight shift/XOR steps of the serial CRC register for one byte.
   function automatic logic [CRC_W-1:0] crc_absorb_byte(
      input logic [CRC_W-1:0]  rem,
      input logic [CRC_W-1:0]  poly,
      input logic [BYTE_W-1:0] data,
      input logic              lsb_first
   );
      logic [CRC_W-1:0] r;
      logic             b;
      logic             fb;
      r = rem;
      for (int k = 0; k < BYTE_W; k++) begin
         b  = lsb_first ? data[k] : data[BYTE_W-1-k];
         fb = r[CRC_W-1] ^ b;
         r  = {r[CRC_W-2:0], 1'b0} ^ (fb ? poly : '0);
      end
      return r;
   endfunction

   function automatic logic [CRC_W-1:0] bit_reverse(input logic [CRC_W-1:0] v);
      logic [CRC_W-1:0] r;
      r = '0;
      for (int k = 0; k < CRC_W; k++) begin
         r[k] = v[CRC_W-1-k];
      end
      return r;
   endfunction

endpackage

### rtl/core/configurable_crc32_engine.sv
`timescale 1ns / 1ps

// Byte-wide CRC-32 engine with programmable polynomial, initial value and
// input/output reflection and output inversion. One byte is taken per clock,
// unless a last byte in the input register waits on a busy output register.
// There eight unrolled shift/XOR steps fold the accepted word into the
// remainder. The last byte's CRC goes from the input register into the
// output register once that is free; the output register drives rsp_ ports.
// Only the word marked last produces a result; the remainder then reloads the
// initial value. A stalled result holds in the output register while the next
// byte is still taken; only a further last byte waits for it. Writing the
// initial value also restarts the message. The user must write configuration
// only while the engine is idle; the engine itself does not enforce this.
module configurable_crc32_engine (
   input  logic                                clock,
   input  logic                                reset,
   input  logic                                req_valid,
   output logic                                req_ready,
   input  logic [ccrc_pkg::BYTE_W-1:0]         req_data_byte,
   input  logic                                req_last_byte,
   output logic                                rsp_valid,
   input  logic                                rsp_ready,
   output logic [ccrc_pkg::CRC_W-1:0]          rsp_crc_value,
   input  logic                                csr_we,
   input  logic [ccrc_pkg::CSR_INDEX_W-1:0]    csr_index,
   input  logic [ccrc_pkg::CRC_W-1:0]          csr_wdata
);
   import ccrc_pkg::*;

   logic [CRC_W-1:0]  polynomial_ff, polynomial_in;
   logic [CRC_W-1:0]  initial_value_ff, initial_value_in;
   logic              reflect_input_ff, reflect_input_in;
   logic              reflect_output_ff, reflect_output_in;
   logic              invert_output_ff, invert_output_in;
   logic [CRC_W-1:0]  remainder_ff, remainder_in;

   logic              s1_valid_ff, s1_valid_in;
   logic [BYTE_W-1:0] s1_data_ff, s1_data_in;
   logic              s1_last_ff, s1_last_in;

   logic              rsp_valid_ff, rsp_valid_in;
   logic [CRC_W-1:0]  rsp_crc_ff, rsp_crc_in;

   logic              req_fire;
   logic              out_free;
   logic              s1_fire;
   logic [CRC_W-1:0]  absorbed;
   logic [CRC_W-1:0]  finished;

   assign out_free  = !rsp_valid_ff || rsp_ready;
   assign s1_fire   = s1_valid_ff && (!s1_last_ff || out_free);
   assign req_ready = !s1_valid_ff || s1_fire;
   assign req_fire  = req_valid && req_ready;

   always_comb begin
      absorbed = crc_absorb_byte(remainder_ff, polynomial_ff, s1_data_ff, reflect_input_ff);
      finished = reflect_output_ff ? bit_reverse(absorbed) : absorbed;
      finished = invert_output_ff ? ~finished : finished;
   end

   // configuration
   always_comb begin
      polynomial_in     = polynomial_ff;
      initial_value_in  = initial_value_ff;
      reflect_input_in  = reflect_input_ff;
      reflect_output_in = reflect_output_ff;
      invert_output_in  = invert_output_ff;
      if (csr_we) begin
         case (csr_index)
            CSR_POLYNOMIAL:     polynomial_in     = csr_wdata;
            CSR_INITIAL_VALUE:  initial_value_in  = csr_wdata;
            CSR_REFLECT_INPUT:  reflect_input_in  = csr_wdata[0];
            CSR_REFLECT_OUTPUT: reflect_output_in = csr_wdata[0];
            CSR_INVERT_OUTPUT:  invert_output_in  = csr_wdata[0];
            default: ;
         endcase
      end
   end

   // remainder: a write of the initial value restarts the message
   always_comb begin
      remainder_in = remainder_ff;
      if (s1_fire) begin
         remainder_in = s1_last_ff ? initial_value_ff : absorbed;
      end
      if (csr_we && csr_index == CSR_INITIAL_VALUE) begin
         remainder_in = csr_wdata;
      end
   end

   always_comb begin
      s1_valid_in = s1_valid_ff;
      s1_data_in  = s1_data_ff;
      s1_last_in  = s1_last_ff;
      if (req_fire) begin
         s1_valid_in = 1'b1;
         s1_data_in  = req_data_byte;
         s1_last_in  = req_last_byte;
      end else if (s1_fire) begin
         s1_valid_in = 1'b0;
      end
   end

   always_comb begin
      rsp_valid_in = rsp_valid_ff;
      rsp_crc_in   = rsp_crc_ff;
      if (s1_fire && s1_last_ff) begin
         rsp_valid_in = 1'b1;
         rsp_crc_in   = finished;
      end else if (rsp_ready) begin
         rsp_valid_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         polynomial_ff     <= RESET_POLYNOMIAL;
         initial_value_ff  <= RESET_INITIAL;
         reflect_input_ff  <= 1'b1;
         reflect_output_ff <= 1'b1;
         invert_output_ff  <= 1'b1;
         remainder_ff      <= RESET_INITIAL;
         s1_valid_ff       <= 1'b0;
         rsp_valid_ff      <= 1'b0;
      end else begin
         polynomial_ff     <= polynomial_in;
         initial_value_ff  <= initial_value_in;
         reflect_input_ff  <= reflect_input_in;
         reflect_output_ff <= reflect_output_in;
         invert_output_ff  <= invert_output_in;
         remainder_ff      <= remainder_in;
         s1_valid_ff       <= s1_valid_in;
         rsp_valid_ff      <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      s1_data_ff <= s1_data_in;
      s1_last_ff <= s1_last_in;
      rsp_crc_ff <= rsp_crc_in;
   end

   assign rsp_valid     = rsp_valid_ff;
   assign rsp_crc_value = rsp_crc_ff;

   // a last word may not overwrite a result that is still waiting
   a_no_result_overrun: assert property (@(posedge clock) disable iff (reset)
      (s1_valid_ff && s1_last_ff && rsp_valid_ff && !rsp_ready) |-> !req_ready)
      else $error("last word would overwrite a pending result");

   a_reload_after_last: assert property (@(posedge clock) disable iff (reset)
      (s1_fire && s1_last_ff) |=> (remainder_ff == initial_value_ff))
      else $error("remainder not reloaded after finished message");

   a_restart_on_init_write: assert property (@(posedge clock) disable iff (reset)
      (csr_we && csr_index == CSR_INITIAL_VALUE) |=> (remainder_ff == initial_value_ff))
      else $error("initial value write did not restart the remainder");

   a_result_follows_last: assert property (@(posedge clock) disable iff (reset)
      (s1_fire && s1_last_ff) |=> rsp_valid_ff)
      else $error("finished message produced no result");

endmodule
